FILE: hw/rtl/sca_pkg.sv
package sca_pkg;

   localparam logic [1:0] OP_SCANCODE = 2'd0;
   localparam logic [1:0] OP_SERIAL   = 2'd1;
   localparam logic [1:0] OP_READ     = 2'd2;

   localparam logic [7:0] SC_LSHIFT  = 8'h2A;
   localparam logic [7:0] SC_RSHIFT  = 8'h36;
   localparam logic [7:0] SC_RELEASE = 8'h80;
   localparam logic [7:0] SC_LIMIT   = 8'h3A;

   localparam int KEY_COUNT = 58;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic       is_empty;
      logic [7:0] read_byte;
   } rsp_type;

   typedef struct packed {
      logic       shift_set;
      logic       shift_clr;
      logic       push;
      logic [7:0] ch;
   } key_action_type;

   localparam logic [7:0] PLAIN_KEYS [0:KEY_COUNT-1] = '{
      8'd0,   8'd27,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,
      8'd55,  8'd56,  8'd57,  8'd48,  8'd45,  8'd61,  8'd8,
      8'd9,   8'd113, 8'd119, 8'd101, 8'd114, 8'd116, 8'd121, 8'd117,
      8'd105, 8'd111, 8'd112, 8'd91,  8'd93,  8'd10,
      8'd0,   8'd97,  8'd115, 8'd100, 8'd102, 8'd103, 8'd104, 8'd106,
      8'd107, 8'd108, 8'd59,  8'd39,  8'd96,
      8'd0,   8'd92,  8'd122, 8'd120, 8'd99,  8'd118, 8'd98,  8'd110,
      8'd109, 8'd44,  8'd46,  8'd47,
      8'd0,   8'd42,  8'd0,   8'd32
   };

   localparam logic [7:0] SHIFTED_KEYS [0:KEY_COUNT-1] = '{
      8'd0,   8'd27,  8'd33,  8'd64,  8'd35,  8'd36,  8'd37,  8'd94,
      8'd38,  8'd42,  8'd40,  8'd41,  8'd95,  8'd43,  8'd8,
      8'd9,   8'd81,  8'd87,  8'd69,  8'd82,  8'd84,  8'd89,  8'd85,
      8'd73,  8'd79,  8'd80,  8'd123, 8'd125, 8'd10,
      8'd0,   8'd65,  8'd83,  8'd68,  8'd70,  8'd71,  8'd72,  8'd74,
      8'd75,  8'd76,  8'd58,  8'd34,  8'd126,
      8'd0,   8'd124, 8'd90,  8'd88,  8'd67,  8'd86,  8'd66,  8'd78,
      8'd77,  8'd60,  8'd62,  8'd63,
      8'd0,   8'd42,  8'd0,   8'd32
   };

   function automatic logic [7:0] key_char(input logic shifted, input logic [5:0] code);
      logic [7:0] ch;
      ch = 8'd0;
      if (code < 6'(KEY_COUNT)) begin
         ch = shifted ? SHIFTED_KEYS[code] : PLAIN_KEYS[code];
      end
      return ch;
   endfunction

endpackage

FILE: hw/rtl/sca_ram.sv
module sca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/sca_keymap.sv
module sca_keymap (
   input  logic                    shift_held,
   input  logic [7:0]              code,
   output sca_pkg::key_action_type action
);

   logic       press_shift;
   logic       release_shift;
   logic [7:0] ch;

   always_comb begin
      press_shift   = (code == sca_pkg::SC_LSHIFT) || (code == sca_pkg::SC_RSHIFT);
      release_shift = (code == (sca_pkg::SC_LSHIFT | sca_pkg::SC_RELEASE)) ||
                      (code == (sca_pkg::SC_RSHIFT | sca_pkg::SC_RELEASE));
      ch            = sca_pkg::key_char(shift_held, code[5:0]);

      action.shift_set = press_shift;
      action.shift_clr = release_shift;
      action.ch        = ch;
      action.push      = !press_shift && !code[7] && (code < sca_pkg::SC_LIMIT) &&
                         (ch != 8'd0);
   end

endmodule

FILE: hw/rtl/scancode_to_ascii_fifo.sv
// a read request passes the s1, s2 and result registers in order; a stalled result side holds it
// throughput: one word per cycle on both channels when the result side is not stalled
// pushes and shift codes update state when they leave the s1 register and give no result
// reset clears the pointers, the shift flag and all pipeline valids
// the byte store is not cleared; entries are read only after being written
module scancode_to_ascii_fifo #(
   parameter int FIFO_DEPTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sca_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sca_pkg::rsp_type rsp_payload
);

   localparam int AW = $clog2(FIFO_DEPTH);

   logic             s1_valid_ff, s1_valid_in;
   sca_pkg::req_type s1_req_ff;
   logic             s2_valid_ff, s2_valid_in;
   logic             s2_empty_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   sca_pkg::rsp_type rsp_payload_ff;

   logic          shift_ff, shift_in;
   logic [AW-1:0] wr_pos_ff, wr_pos_in;
   logic [AW-1:0] rd_pos_ff, rd_pos_in;

   sca_pkg::key_action_type action;

   logic          out_free, s2_free, s1_is_read, s1_fire, req_fire;
   logic          fifo_empty, fifo_full;
   logic [AW-1:0] wr_next, rd_next;
   logic          push_req, push_ok, pop_ok;
   logic [7:0]    push_byte;
   logic [7:0]    ram_rd_data;

   sca_keymap u_keymap (
      .shift_held (shift_ff),
      .code       (s1_req_ff.data_byte),
      .action     (action)
   );

   sca_ram #(
      .WIDTH (8),
      .DEPTH (FIFO_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (push_ok),
      .wr_addr (wr_pos_ff),
      .wr_data (push_byte),
      .rd_en   (pop_ok),
      .rd_addr (rd_pos_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      out_free   = !rsp_valid_ff || rsp_ready;
      s2_free    = !s2_valid_ff || out_free;
      s1_is_read = (s1_req_ff.operation == sca_pkg::OP_READ);
      s1_fire    = s1_valid_ff && (!s1_is_read || s2_free);
      req_ready  = !s1_valid_ff || s1_fire;
      req_fire   = req_valid && req_ready;

      wr_next    = (wr_pos_ff == AW'(FIFO_DEPTH - 1)) ? '0 : wr_pos_ff + 1'b1;
      rd_next    = (rd_pos_ff == AW'(FIFO_DEPTH - 1)) ? '0 : rd_pos_ff + 1'b1;
      fifo_empty = (wr_pos_ff == rd_pos_ff);
      fifo_full  = (wr_next == rd_pos_ff);

      push_req  = 1'b0;
      push_byte = s1_req_ff.data_byte;
      shift_in  = shift_ff;
      unique case (s1_req_ff.operation)
         sca_pkg::OP_SCANCODE: begin
            push_req  = action.push;
            push_byte = action.ch;
            if (s1_fire && action.shift_set) begin
               shift_in = 1'b1;
            end else if (s1_fire && action.shift_clr) begin
               shift_in = 1'b0;
            end
         end
         sca_pkg::OP_SERIAL: begin
            push_req = 1'b1;
         end
         default: begin
            push_req = 1'b0;
         end
      endcase

      push_ok   = s1_fire && push_req && !fifo_full;
      pop_ok    = s1_fire && s1_is_read && !fifo_empty;
      wr_pos_in = push_ok ? wr_next : wr_pos_ff;
      rd_pos_in = pop_ok ? rd_next : rd_pos_ff;

      s1_valid_in = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
      s2_valid_in = (s1_fire && s1_is_read) ? 1'b1 : (out_free ? 1'b0 : s2_valid_ff);
      rsp_valid_in = out_free ? s2_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         shift_ff     <= 1'b0;
         wr_pos_ff    <= '0;
         rd_pos_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         shift_ff     <= shift_in;
         wr_pos_ff    <= wr_pos_in;
         rd_pos_ff    <= rd_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff <= req_payload;
      end
      if (s1_fire && s1_is_read) begin
         s2_empty_ff <= fifo_empty;
      end
      if (out_free && s2_valid_ff) begin
         rsp_payload_ff.is_empty  <= s2_empty_ff;
         rsp_payload_ff.read_byte <= s2_empty_ff ? 8'd0 : ram_rd_data;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

FILE: hw/rtl/sca_checker.sv
module sca_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input sca_pkg::req_type req_payload,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sca_pkg::rsp_type rsp_payload
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_payload))
      else $error("request word changed while waiting");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result word changed while stalled");

   a_reset_no_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("request side not ready after reset");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.is_empty |-> rsp_payload.read_byte == 8'd0)
      else $error("empty read carries a nonzero byte");

endmodule

bind scancode_to_ascii_fifo sca_checker u_sca_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
